[src/utt_pkg.sv]
// Shared types and constants for the UTF-8 to UTF-16 transcoder.
package utt_pkg;

   localparam int LENGTH_BITS_DEFAULT = 24;
   localparam int NUM_SLOTS = 4;
   localparam int SLOT_BITS = 2;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [15:0] REPLACEMENT = 16'hFFFD;
   localparam logic [20:0] MAX_SCALAR = 21'h10FFFF;
   localparam logic [20:0] SUPPLEMENTARY_BASE = 21'h010000;
   localparam logic [5:0] HIGH_SURROGATE_TAG = 6'b110110;
   localparam logic [5:0] LOW_SURROGATE_TAG = 6'b110111;

   localparam logic [1:0] CONT_TAG = 2'b10;

   typedef struct packed {
      logic [SLOT_BITS-1:0] last_idx;
      logic last;
      logic [NUM_SLOTS-1:0][15:0] units;
   } utt_job_type;

endpackage

[src/utt_front.sv]
// Front end: takes bytes, tracks the UTF-8 sequence state and builds jobs of code units; not every byte yields a job.
module utt_front import utt_pkg::*; #(
   parameter int LENGTH_BITS = LENGTH_BITS_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [LENGTH_BITS-1:0] csr_string_length,
   input  logic req_valid,
   output logic req_ready,
   input  logic [7:0] req_byte_value,
   input  logic queue_full,
   output logic job_push,
   output utt_job_type job
);

   logic [LENGTH_BITS-1:0] length_ff, length_in;
   logic [LENGTH_BITS-1:0] pos_ff, pos_in;
   logic [1:0] expected_ff, expected_in;
   logic [1:0] seen_ff, seen_in;
   logic [20:0] partial_ff, partial_in;
   logic swallow_ff, swallow_in;

   logic accept;
   logic active;
   logic [LENGTH_BITS-1:0] remaining;
   logic is_final;
   logic [7:0] b;
   logic is_cont;

   logic [1:0] lead_extra;
   logic [20:0] lead_init;
   logic lead_opens;
   logic lead_fit_fail;
   logic [15:0] lead_unit;

   logic [20:0] scalar;
   logic [19:0] offset;
   logic [1:0] seen_next;
   logic [SLOT_BITS-1:0] n_pre;

   assign csr_ready = 1'b1;
   assign req_ready = !queue_full;
   assign accept = req_valid && req_ready;
   assign b = req_byte_value;
   assign active = pos_ff < length_ff;
   assign remaining = length_ff - pos_ff;
   assign is_final = remaining == LENGTH_BITS'(1);
   assign is_cont = b[7:6] == CONT_TAG;

   always_comb begin
      lead_extra = 2'd0;
      lead_init = '0;
      lead_opens = 1'b0;
      lead_fit_fail = 1'b0;
      lead_unit = REPLACEMENT;
      if (b < 8'h80) begin
         lead_unit = {8'h00, b};
      end else begin
         if (b inside {[8'hC0:8'hDF]}) begin
            lead_extra = 2'd1;
            lead_init = {16'h0000, b[4:0]};
         end else if (b inside {[8'hE0:8'hEF]}) begin
            lead_extra = 2'd2;
            lead_init = {17'h00000, b[3:0]};
         end else if (b inside {[8'hF0:8'hF7]}) begin
            lead_extra = 2'd3;
            lead_init = {18'h00000, b[2:0]};
         end
         if (lead_extra != 2'd0) begin
            if ((remaining[LENGTH_BITS-1:2] == '0) && (remaining[1:0] <= lead_extra)) begin
               lead_fit_fail = 1'b1;
            end else begin
               lead_opens = 1'b1;
            end
         end
      end
   end

   assign scalar = {partial_ff[14:0], b[5:0]};
   assign offset = 20'(scalar - SUPPLEMENTARY_BASE);
   assign seen_next = seen_ff + 2'd1;

   always_comb begin
      length_in = length_ff;
      pos_in = pos_ff;
      expected_in = expected_ff;
      seen_in = seen_ff;
      partial_in = partial_ff;
      swallow_in = swallow_ff;
      job_push = 1'b0;
      job.last = is_final;
      job.last_idx = '0;
      job.units = {NUM_SLOTS{REPLACEMENT}};
      n_pre = '0;

      if (csr_valid && csr_ready) begin
         length_in = csr_string_length;
         pos_in = '0;
         expected_in = 2'd0;
         seen_in = 2'd0;
         partial_in = '0;
         swallow_in = 1'b0;
      end else if (accept && active) begin
         pos_in = pos_ff + LENGTH_BITS'(1);
         if (!swallow_ff) begin
            if (expected_ff != 2'd0 && is_cont) begin
               if (seen_next >= expected_ff) begin
                  job_push = 1'b1;
                  expected_in = 2'd0;
                  seen_in = 2'd0;
                  partial_in = '0;
                  if (scalar > MAX_SCALAR) begin
                     job.units[0] = REPLACEMENT;
                  end else if (scalar[20:16] != 5'd0) begin
                     job.units[0] = {HIGH_SURROGATE_TAG, offset[19:10]};
                     job.units[1] = {LOW_SURROGATE_TAG, offset[9:0]};
                     job.last_idx = SLOT_BITS'(1);
                  end else begin
                     job.units[0] = scalar[15:0];
                  end
               end else begin
                  seen_in = seen_next;
                  partial_in = scalar;
               end
            end else begin
               if (expected_ff != 2'd0) begin
                  n_pre = SLOT_BITS'(seen_ff) + SLOT_BITS'(1);
               end
               expected_in = 2'd0;
               seen_in = 2'd0;
               partial_in = '0;
               for (int k = 0; k < NUM_SLOTS; k++) begin
                  if (SLOT_BITS'(k) == n_pre) begin
                     job.units[k] = lead_unit;
                  end
               end
               if (lead_opens) begin
                  expected_in = lead_extra;
                  partial_in = lead_init;
                  job_push = n_pre != '0;
                  job.last_idx = n_pre - SLOT_BITS'(1);
               end else begin
                  job_push = 1'b1;
                  job.last_idx = n_pre;
                  if (lead_fit_fail) begin
                     job.last = 1'b1;
                     swallow_in = 1'b1;
                  end
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff <= '0;
         pos_ff <= '0;
         expected_ff <= 2'd0;
         seen_ff <= 2'd0;
         partial_ff <= '0;
         swallow_ff <= 1'b0;
      end else begin
         length_ff <= length_in;
         pos_ff <= pos_in;
         expected_ff <= expected_in;
         seen_ff <= seen_in;
         partial_ff <= partial_in;
         swallow_ff <= swallow_in;
      end
   end

endmodule

[src/utt_job_queue.sv]
// Short job queue between the front end and the back end.
module utt_job_queue import utt_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  logic push,
   input  utt_job_type push_job,
   input  logic pop,
   output logic full,
   output logic empty,
   output utt_job_type head
);

   localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int COUNT_BITS = $clog2(QUEUE_DEPTH + 1);

   utt_job_type mem_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic do_push;
   logic do_pop;

   assign full = count_ff == COUNT_BITS'(QUEUE_DEPTH);
   assign empty = count_ff == '0;
   assign head = mem_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_BITS'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_BITS'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + COUNT_BITS'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - COUNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

endmodule

[src/utt_back.sv]
// Back end: sends the code units of each queued job one per transfer through an output register.
module utt_back import utt_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  logic queue_empty,
   input  utt_job_type head,
   output logic pop,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic [15:0] rsp_code_unit,
   output logic rsp_last
);

   logic rsp_valid_ff, rsp_valid_in;
   logic [15:0] code_unit_ff;
   logic last_ff;
   logic [SLOT_BITS-1:0] idx_ff, idx_in;
   logic load;
   logic final_unit;

   assign load = !queue_empty && (!rsp_valid_ff || rsp_ready);
   assign final_unit = idx_ff == head.last_idx;
   assign pop = load && final_unit;

   always_comb begin
      idx_in = idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (load) begin
         rsp_valid_in = 1'b1;
         idx_in = final_unit ? '0 : idx_ff + SLOT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         code_unit_ff <= head.units[idx_ff];
         last_ff <= head.last && final_unit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         idx_ff <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         idx_ff <= idx_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_code_unit = code_unit_ff;
   assign rsp_last = last_ff;

endmodule

[src/utf8_to_utf16_transcoder_top.sv]
// Top level of the UTF-8 to UTF-16 transcoder: front end, job queue and back end.
// A byte is taken every cycle while the two-entry job queue has room; the code units it
// yields pass through the queue and the back end's output register, and the back end
// sends one code unit per cycle while rsp_ready is high.
// Synchronous reset clears the string length, the decoder state, the queue and the output valid flag.
module utf8_to_utf16_transcoder_top import utt_pkg::*; #(
   parameter int LENGTH_BITS = LENGTH_BITS_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [LENGTH_BITS-1:0] csr_string_length,
   input  logic req_valid,
   output logic req_ready,
   input  logic [7:0] req_byte_value,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic [15:0] rsp_code_unit,
   output logic rsp_last
);

   utt_job_type push_job;
   utt_job_type head;
   logic job_push;
   logic queue_full;
   logic queue_empty;
   logic pop;

   utt_front #(
      .LENGTH_BITS(LENGTH_BITS)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_string_length(csr_string_length),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_byte_value(req_byte_value),
      .queue_full(queue_full),
      .job_push(job_push),
      .job(push_job)
   );

   utt_job_queue u_queue (
      .clock(clock),
      .reset(reset),
      .push(job_push),
      .push_job(push_job),
      .pop(pop),
      .full(queue_full),
      .empty(queue_empty),
      .head(head)
   );

   utt_back u_back (
      .clock(clock),
      .reset(reset),
      .queue_empty(queue_empty),
      .head(head),
      .pop(pop),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_code_unit(rsp_code_unit),
      .rsp_last(rsp_last)
   );

endmodule
